// ===== hw/rtl/hpid_pkg.sv =====
// Types, widths and codes shared by the heater PID blocks.
package hpid_pkg;

  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ES_W       = 24;
  localparam int unsigned FD_W       = 32;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned PWR_W      = 8 + FRAC_BITS;
  localparam int unsigned SUM_W      = TEMP_W + 2;
  localparam int unsigned MAG_W      = SUM_W - 1;
  localparam int unsigned ERR_W      = TEMP_W + 1;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 18;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W      = 44;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned IN_DATA_W  = 3 * TEMP_W;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [TEMP_W-1:0] TARGET_RST = 16'd0;
  localparam logic [TEMP_W-1:0] CUTOFF_RST = 16'd1600;
  localparam logic [TEMP_W-1:0] VLOW_RST   = 16'd0;
  localparam logic [TEMP_W-1:0] VHIGH_RST  = 16'd1600;

  typedef enum logic [2:0] {
    REG_TARGET,
    REG_CUTOFF,
    REG_VLOW,
    REG_VHIGH,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_ILIMIT
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_FD_K,
    MUL_GD_DM,
    MUL_RAW_K,
    MUL_GP_ERR,
    MUL_GI_ES
  } mul_sel_e;

  typedef enum logic [1:0] {
    DS_HOLD,
    DS_LOAD,
    DS_ADD
  } ds_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB_FD
  } acc_op_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic signed [TEMP_W-1:0] cutoff_temp;
    logic signed [TEMP_W-1:0] valid_low_temp;
    logic signed [TEMP_W-1:0] valid_high_temp;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
    logic [ES_W-1:0]          integral_limit;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     avg_en;
    logic     dec_en;
    mul_sel_e mul_sel;
    ds_op_e   ds_op;
    acc_op_e  acc_op;
    logic     fd_en;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic trip;
  } dp_sts_t;

endpackage

// ===== hw/rtl/hpid_regs.sv =====
// Configuration register file with APB-style access.
module hpid_regs import hpid_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              tgt_wr_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign pready   = 1'b1;
  assign idx      = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr       = psel & penable & pwrite & pready;
  assign tgt_wr_o = wr && (idx == REG_TARGET);
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp     <= TARGET_RST;
      cfg_q.cutoff_temp     <= CUTOFF_RST;
      cfg_q.valid_low_temp  <= VLOW_RST;
      cfg_q.valid_high_temp <= VHIGH_RST;
      cfg_q.gain_p          <= '0;
      cfg_q.gain_i          <= '0;
      cfg_q.gain_d          <= '0;
      cfg_q.integral_limit  <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_TARGET: cfg_q.target_temp     <= pwdata[TEMP_W-1:0];
        REG_CUTOFF: cfg_q.cutoff_temp     <= pwdata[TEMP_W-1:0];
        REG_VLOW:   cfg_q.valid_low_temp  <= pwdata[TEMP_W-1:0];
        REG_VHIGH:  cfg_q.valid_high_temp <= pwdata[TEMP_W-1:0];
        REG_GAIN_P: cfg_q.gain_p          <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: cfg_q.gain_i          <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: cfg_q.gain_d          <= pwdata[GAIN_W-1:0];
        REG_ILIMIT: cfg_q.integral_limit  <= pwdata[ES_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET: prdata = {{(APB_DW-TEMP_W){1'b0}}, cfg_q.target_temp};
      REG_CUTOFF: prdata = {{(APB_DW-TEMP_W){1'b0}}, cfg_q.cutoff_temp};
      REG_VLOW:   prdata = {{(APB_DW-TEMP_W){1'b0}}, cfg_q.valid_low_temp};
      REG_VHIGH:  prdata = {{(APB_DW-TEMP_W){1'b0}}, cfg_q.valid_high_temp};
      REG_GAIN_P: prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_q.gain_p};
      REG_GAIN_I: prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_q.gain_i};
      REG_GAIN_D: prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_q.gain_d};
      REG_ILIMIT: prdata = {{(APB_DW-ES_W){1'b0}}, cfg_q.integral_limit};
    endcase
  end

endmodule

// ===== hw/rtl/hpid_ctrl.sv =====
// Sequencer for one control tick: average, decide, multiply steps, result.
module hpid_ctrl import hpid_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_DEC,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_ld;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  // load the result word only once the output slot is free or being drained
  assign out_ld      = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o        = '0;
    cmd_o.out_ld = out_ld;
    unique case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_AVG:  cmd_o.avg_en = 1'b1;
      ST_DEC: begin
        cmd_o.dec_en  = 1'b1;
        cmd_o.mul_sel = MUL_FD_K;
      end
      ST_M1: begin
        cmd_o.mul_sel = MUL_GD_DM;
        cmd_o.ds_op   = DS_LOAD;
      end
      ST_M2: cmd_o.mul_sel = MUL_RAW_K;
      ST_M3: begin
        cmd_o.mul_sel = MUL_GP_ERR;
        cmd_o.ds_op   = DS_ADD;
      end
      ST_M4: begin
        cmd_o.mul_sel = MUL_GI_ES;
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.fd_en   = 1'b1;
      end
      ST_M5:   cmd_o.acc_op = ACC_ADD;
      ST_M6:   cmd_o.acc_op = ACC_SUB_FD;
      ST_FIN:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_AVG;
        ST_AVG:  state_q <= ST_DEC;
        ST_DEC:  state_q <= sts_i.trip ? ST_FIN : ST_M1;
        ST_M1:   state_q <= ST_M2;
        ST_M2:   state_q <= ST_M3;
        ST_M3:   state_q <= ST_M4;
        ST_M4:   state_q <= ST_M5;
        ST_M5:   state_q <= ST_M6;
        ST_M6:   state_q <= ST_FIN;
        ST_FIN:  if (out_ld) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/hpid_dp.sv =====
// Datapath: sensor average, cutoff and window checks, shared multiplier, PID state.
module hpid_dp import hpid_pkg::*; #(
  parameter int unsigned SENSOR_COUNT    = 3,
  parameter int unsigned MAX_POWER       = 255,
  parameter int unsigned DERIV_SMOOTH_Q8 = 243
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              tgt_wr_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [TEMP_W-1:0] sensor_temp_0_i,
  input  logic [TEMP_W-1:0] sensor_temp_1_i,
  input  logic [TEMP_W-1:0] sensor_temp_2_i,
  output logic [DUTY_W-1:0] heater_duty_o,
  output logic [TEMP_W-1:0] average_temp_o,
  output logic              cutoff_active_o,
  output logic              out_of_window_o
);

  localparam logic [MAG_W-1:0]   RECIP3 = MAG_W'(((1 << MAG_W) + 2) / 3);
  localparam logic [MUL_B_W-1:0] K_B    = MUL_B_W'(DERIV_SMOOTH_Q8);
  localparam logic [MUL_B_W-1:0] KC_B   = MUL_B_W'(256 - DERIV_SMOOTH_Q8);
  localparam logic [PWR_W-1:0]   PMAX   = PWR_W'(MAX_POWER) << FRAC_BITS;

  // PID state
  logic [ES_W-1:0]   error_sum_q;
  logic [TEMP_W-1:0] prev_q;
  logic [FD_W-1:0]   fd_q;
  logic              tripped_q;

  // per-tick working registers
  logic [SUM_W-1:0]  sum_q;
  logic [TEMP_W-1:0] avg_q;
  logic [ERR_W-1:0]  err_q;
  logic [ERR_W-1:0]  dmeas_q;
  logic              trip_q;
  logic              oow_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  dsum_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DUTY_W-1:0] duty_q;
  logic [TEMP_W-1:0] avg_out_q;
  logic              cut_q;
  logic              oow_out_q;

  logic [SUM_W-1:0]   sum_d;
  logic [SUM_W-1:0]   s0, s1, s2;
  logic [SUM_W-1:0]   mag_full;
  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W-1:0] qprod;
  logic [MAG_W-1:0]   quot;
  logic [MAG_W-1:0]   quot_neg;
  logic [TEMP_W-1:0]  avg_d;

  logic [TEMP_W-1:0] tgt;
  logic [ERR_W-1:0]  err_d;
  logic [ERR_W-1:0]  dmeas_d;
  logic [ES_W+1:0]   es_sum;
  logic [ES_W-1:0]   es_clamp;
  logic              trip;
  logic              in_win;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_d;
  logic [ACC_W-1:0]   dsr;
  logic               fd_ovf;
  logic [FD_W-1:0]    fd_sat;
  logic [PWR_W-1:0]   pclamp;

  // unused channels of the sample word are dropped
  assign s0    = {{2{sensor_temp_0_i[TEMP_W-1]}}, sensor_temp_0_i};
  assign s1    = (SENSOR_COUNT > 1) ? {{2{sensor_temp_1_i[TEMP_W-1]}}, sensor_temp_1_i} : '0;
  assign s2    = (SENSOR_COUNT > 2) ? {{2{sensor_temp_2_i[TEMP_W-1]}}, sensor_temp_2_i} : '0;
  assign sum_d = s0 + s1 + s2;

  // divide by the sensor count on the magnitude so the result truncates toward zero
  always_comb begin
    mag_full = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
    mag      = mag_full[MAG_W-1:0];
    qprod    = mag * RECIP3;
    if (SENSOR_COUNT == 3) begin
      quot = qprod[2*MAG_W-1:MAG_W];
    end else if (SENSOR_COUNT == 2) begin
      quot = mag >> 1;
    end else begin
      quot = mag;
    end
    quot_neg = MAG_W'(0) - quot;
    avg_d    = sum_q[SUM_W-1] ? quot_neg[TEMP_W-1:0] : quot[TEMP_W-1:0];
  end

  always_comb begin
    trip    = $signed(avg_q) > $signed(cfg_i.cutoff_temp);
    in_win  = ($signed(avg_q) > $signed(cfg_i.valid_low_temp)) &&
              ($signed(avg_q) < $signed(cfg_i.valid_high_temp));
    tgt     = tripped_q ? '0 : cfg_i.target_temp;
    err_d   = {tgt[TEMP_W-1], tgt} - {avg_q[TEMP_W-1], avg_q};
    dmeas_d = {avg_q[TEMP_W-1], avg_q} - {prev_q[TEMP_W-1], prev_q};
    es_sum  = {2'b00, error_sum_q} + {{(ES_W+2-ERR_W){err_d[ERR_W-1]}}, err_d};
    if (es_sum[ES_W+1]) begin
      es_clamp = '0;
    end else if (es_sum[ES_W:0] > {1'b0, cfg_i.integral_limit}) begin
      es_clamp = cfg_i.integral_limit;
    end else begin
      es_clamp = es_sum[ES_W-1:0];
    end
  end

  assign sts_o.trip = trip;

  // shared signed multiplier, operands picked by the sequencer
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_FD_K: begin
        mul_a = {{(MUL_A_W-FD_W){fd_q[FD_W-1]}}, fd_q};
        mul_b = K_B;
      end
      MUL_GD_DM: begin
        mul_a = {{(MUL_A_W-ERR_W){dmeas_q[ERR_W-1]}}, dmeas_q};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.gain_d};
      end
      MUL_RAW_K: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = KC_B;
      end
      MUL_GP_ERR: begin
        mul_a = {{(MUL_A_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.gain_p};
      end
      MUL_GI_ES: begin
        mul_a = {{(MUL_A_W-ES_W){1'b0}}, error_sum_q};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.gain_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = $signed(mul_a) * $signed(mul_b);

  // floor divide by 256, then saturate to the filter register
  always_comb begin
    dsr    = $signed(dsum_q) >>> 8;
    fd_ovf = !((&dsr[ACC_W-1:FD_W-1]) || !(|dsr[ACC_W-1:FD_W-1]));
    if (fd_ovf) begin
      fd_sat = dsr[ACC_W-1] ? {1'b1, {(FD_W-1){1'b0}}} : {1'b0, {(FD_W-1){1'b1}}};
    end else begin
      fd_sat = dsr[FD_W-1:0];
    end
  end

  always_comb begin
    if (acc_q[ACC_W-1]) begin
      pclamp = '0;
    end else if (acc_q > {{(ACC_W-PWR_W){1'b0}}, PMAX}) begin
      pclamp = PMAX;
    end else begin
      pclamp = acc_q[PWR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      prev_q      <= '0;
      fd_q        <= '0;
      tripped_q   <= 1'b0;
    end else begin
      if (tgt_wr_i) begin
        tripped_q <= 1'b0;
      end else if (cmd_i.dec_en && trip) begin
        tripped_q <= 1'b1;
      end
      if (cmd_i.dec_en && !trip) begin
        error_sum_q <= es_clamp;
      end
      if (cmd_i.fd_en) begin
        fd_q   <= fd_sat;
        prev_q <= avg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      sum_q <= sum_d;
    end
    if (cmd_i.avg_en) begin
      avg_q <= avg_d;
    end
    if (cmd_i.dec_en) begin
      trip_q  <= trip;
      oow_q   <= !trip && !in_win;
      err_q   <= err_d;
      dmeas_q <= dmeas_d;
    end
    unique case (cmd_i.ds_op)
      DS_LOAD: dsum_q <= prod_q[ACC_W-1:0];
      DS_ADD:  dsum_q <= dsum_q + prod_q[ACC_W-1:0];
      default: ;
    endcase
    unique case (cmd_i.acc_op)
      ACC_LOAD:   acc_q <= prod_q[ACC_W-1:0];
      ACC_ADD:    acc_q <= acc_q + prod_q[ACC_W-1:0];
      ACC_SUB_FD: acc_q <= acc_q - {{(ACC_W-FD_W){fd_q[FD_W-1]}}, fd_q};
      default:    ;
    endcase
    if (cmd_i.out_ld) begin
      duty_q    <= (trip_q || oow_q) ? '0 : pclamp[PWR_W-1:FRAC_BITS+1];
      avg_out_q <= avg_q;
      cut_q     <= tripped_q;
      oow_out_q <= oow_q;
    end
  end

  assign heater_duty_o   = duty_q;
  assign average_temp_o  = avg_out_q;
  assign cutoff_active_o = cut_q;
  assign out_of_window_o = oow_out_q;

endmodule

// ===== hw/rtl/heater_pid_with_cutoff_top.sv =====
// Operation: a PID tick steps through average, decide, the multiply states M1 to M6 and
// finish; a cutoff tick goes from decide straight to finish. The result word is registered.
// A new word is taken only in idle, so one word is processed at a time; five products share
// one 34x18 multiplier in sequence. One finished word may wait in the output register.
// Reset (rst_ni, async low) restores register defaults and clears PID state,
// the trip flag and both handshakes; no clearing pass is needed.
module heater_pid_with_cutoff_top import hpid_pkg::*; #(
  parameter int unsigned SENSOR_COUNT    = 3,
  parameter int unsigned MAX_POWER       = 255,
  parameter int unsigned DERIV_SMOOTH_Q8 = 243
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sensor_temp_0, sensor_temp_1, sensor_temp_2
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // heater_duty, average_temp, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // cutoff_active, out_of_window
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  cfg_t              cfg;
  logic              tgt_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [DUTY_W-1:0] heater_duty;
  logic [TEMP_W-1:0] average_temp;
  logic              cutoff_active;
  logic              out_of_window;

  hpid_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .tgt_wr_o (tgt_wr)
  );

  hpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hpid_dp #(
    .SENSOR_COUNT    (SENSOR_COUNT),
    .MAX_POWER       (MAX_POWER),
    .DERIV_SMOOTH_Q8 (DERIV_SMOOTH_Q8)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .tgt_wr_i        (tgt_wr),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sensor_temp_0_i (s_axis_tdata[TEMP_W-1:0]),
    .sensor_temp_1_i (s_axis_tdata[2*TEMP_W-1:TEMP_W]),
    .sensor_temp_2_i (s_axis_tdata[3*TEMP_W-1:2*TEMP_W]),
    .heater_duty_o   (heater_duty),
    .average_temp_o  (average_temp),
    .cutoff_active_o (cutoff_active),
    .out_of_window_o (out_of_window)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-DUTY_W-TEMP_W){1'b0}}, average_temp, heater_duty};
  assign m_axis_tuser = {out_of_window, cutoff_active};

endmodule

// ===== hw/rtl/hpid_checker.sv =====
// Port-level checks for the heater PID top level, bound to every instance.
module hpid_port_checks import hpid_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one tick at a time: no second word right after an accepted one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  // a fresh result never rises while an accepted word is still in its average or decide step
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(in_acc) && !$past(in_acc, 2))
    else $error("result appeared too soon after input");

  // outside the window the duty is forced to zero
  a_oow_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[DUTY_W-1:0] == '0)
    else $error("nonzero duty with average out of window");

endmodule

bind heater_pid_with_cutoff_top hpid_port_checks u_hpid_checker (.*);
